[rtl/tplq_pkg.sv]
// Shared types and constants for the three-level priority queue unit.
// No dependencies; every other file but tplq_ram uses this package.
package tplq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 64;
	localparam int LEVELS      = 3;
	localparam int HANDLE_W    = 16;
	localparam int OCC_W       = 7;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Request modes.
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PUSHED  = 2'd0,
		ST_POPPED  = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	// Level codes.
	localparam logic [1:0] LVL_HIGH    = 2'd0;
	localparam logic [1:0] LVL_MEDIUM  = 2'd1;
	localparam logic [1:0] LVL_LOW     = 2'd2;
	localparam logic [1:0] LVL_INVALID = 2'd3;

	// One request item.
	typedef struct packed {
		logic                mode;
		logic [1:0]          level;
		logic                at_front;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [1:0]          status;
		logic [1:0]          served_level;
		logic [HANDLE_W-1:0] out_handle;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

endpackage

[rtl/tplq_req_if.sv]
// Request channel of the priority queue unit: valid, ready and one request item.
// Depends on tplq_pkg.
interface tplq_req_if;
	logic            valid;
	logic            ready;
	tplq_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/tplq_rsp_if.sv]
// Result channel of the priority queue unit: valid, ready and one result item.
// Depends on tplq_pkg.
interface tplq_rsp_if;
	logic            valid;
	logic            ready;
	tplq_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/tplq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module tplq_ram #(
	parameter int DEPTH  = 192,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tplq_ctrl.sv]
// Queue control: per-level head, tail and count registers, entry store
// addressing, the read stage and the result register. Depends on tplq_pkg,
// tplq_req_if and tplq_rsp_if.
module tplq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	tplq_req_if.sink                  req,
	tplq_rsp_if.source                rsp,
	output logic                      mem_we,
	output logic [tplq_pkg::ADDR_W-1:0]   mem_waddr,
	output logic [tplq_pkg::HANDLE_W-1:0] mem_wdata,
	output logic                      mem_re,
	output logic [tplq_pkg::ADDR_W-1:0]   mem_raddr,
	input  logic [tplq_pkg::HANDLE_W-1:0] mem_rdata
);
	import tplq_pkg::*;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] head_q [LEVELS];
	logic [PTR_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0] cnt_q  [LEVELS];

	logic             accept;
	logic             advance;
	logic [1:0]       sel_lvl;
	logic             sel_ok;
	logic [PTR_W-1:0] sel_head;
	logic [PTR_W-1:0] sel_tail;
	logic [CNT_W-1:0] sel_cnt;
	logic [PTR_W-1:0] head_next;
	logic [PTR_W-1:0] head_prev;
	logic [PTR_W-1:0] tail_next;
	logic [ADDR_W-1:0] base_addr;

	logic             upd_en;
	logic [PTR_W-1:0] upd_head;
	logic [PTR_W-1:0] upd_tail;
	logic [CNT_W-1:0] upd_cnt;
	status_t          res_status;
	logic [1:0]       res_lvl;
	logic [OCC_W-1:0] res_occ;

	logic             valid_s1;
	status_t          status_s1;
	logic [1:0]       lvl_s1;
	logic [OCC_W-1:0] occ_s1;

	logic             out_valid_q;
	rsp_t             out_q;

	// Handshake: the read stage moves on when the result register is free.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	// Pick the level this request touches: the named level on a push, the
	// first non-empty level on a pop.
	always_comb begin
		sel_lvl = req.data.level;
		sel_ok  = (req.data.level != LVL_INVALID);
		if (req.data.mode == MODE_POP) begin
			sel_ok = 1'b1;
			priority if (cnt_q[0] != '0) begin
				sel_lvl = LVL_HIGH;
			end else if (cnt_q[1] != '0) begin
				sel_lvl = LVL_MEDIUM;
			end else if (cnt_q[2] != '0) begin
				sel_lvl = LVL_LOW;
			end else begin
				sel_lvl = LVL_HIGH;
				sel_ok  = 1'b0;
			end
		end
	end

	// Fetch the selected level's pointers and count.
	always_comb begin
		sel_head = '0;
		sel_tail = '0;
		sel_cnt  = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (sel_lvl == 2'(i)) begin
				sel_head = head_q[i];
				sel_tail = tail_q[i];
				sel_cnt  = cnt_q[i];
			end
		end
	end

	// Circular pointer steps and the level's base address in the store.
	assign head_next = (sel_head == PTR_LAST) ? '0 : sel_head + PTR_W'(1);
	assign head_prev = (sel_head == '0) ? PTR_LAST : sel_head - PTR_W'(1);
	assign tail_next = (sel_tail == PTR_LAST) ? '0 : sel_tail + PTR_W'(1);
	assign base_addr = ADDR_W'(sel_lvl) * ADDR_W'(QUEUE_DEPTH);

	// Decide the operation: state update, store access and result fields.
	always_comb begin
		upd_en     = 1'b0;
		upd_head   = sel_head;
		upd_tail   = sel_tail;
		upd_cnt    = sel_cnt;
		mem_we     = 1'b0;
		mem_waddr  = base_addr + ADDR_W'(sel_tail);
		mem_wdata  = req.data.handle;
		mem_re     = 1'b0;
		mem_raddr  = base_addr + ADDR_W'(sel_head);
		res_status = ST_DROPPED;
		res_lvl    = sel_lvl;
		res_occ    = '0;
		if (req.data.mode == MODE_PUSH) begin
			if (!sel_ok) begin
				res_status = ST_DROPPED;
			end else if (sel_cnt >= CNT_FULL) begin
				res_status = ST_DROPPED;
				res_occ    = OCC_W'(sel_cnt);
			end else begin
				upd_en     = accept;
				mem_we     = accept;
				upd_cnt    = sel_cnt + CNT_W'(1);
				res_status = ST_PUSHED;
				res_occ    = OCC_W'(upd_cnt);
				if (req.data.at_front) begin
					upd_head  = head_prev;
					mem_waddr = base_addr + ADDR_W'(head_prev);
				end else begin
					upd_tail  = tail_next;
				end
			end
		end else if (sel_ok) begin
			upd_en     = accept;
			mem_re     = accept;
			upd_head   = head_next;
			upd_cnt    = sel_cnt - CNT_W'(1);
			res_status = ST_POPPED;
			res_occ    = OCC_W'(upd_cnt);
		end else begin
			res_status = ST_EMPTY;
			res_lvl    = LVL_HIGH;
		end
	end

	// Per-level pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (upd_en) begin
			for (int i = 0; i < LEVELS; i++) begin
				if (sel_lvl == 2'(i)) begin
					head_q[i] <= upd_head;
					tail_q[i] <= upd_tail;
					cnt_q[i]  <= upd_cnt;
				end
			end
		end
	end

	// Read stage: holds the request's result fields while the store's registered read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= res_status;
			lvl_s1    <= res_lvl;
			occ_s1    <= res_occ;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.status       <= status_s1;
			out_q.served_level <= lvl_s1;
			out_q.out_handle   <= (status_s1 == ST_POPPED) ? mem_rdata : '0;
			out_q.occupancy    <= occ_s1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

[rtl/three_level_priority_queue_unit.sv]
// Top level of the three-level strict-priority queue unit.
// Depends on tplq_pkg, tplq_req_if, tplq_rsp_if, tplq_ram and tplq_ctrl.
//
//  Channel | Role   | Payload
//  --------+--------+-----------------------------------------------
//  req     | sink   | mode, level, at_front, handle
//  rsp     | source | status, served_level, out_handle, occupancy
//
// One request is taken per cycle while no result is stalled; each gives one
// result after it is accepted, passing through the read stage for the entry
// store's registered read and then through the result register.
// Reset empties all three queues at once; the store itself needs no clearing.
// A stalled result holds in its register while the read stage still takes
// one more request behind it.
module three_level_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	tplq_req_if.sink    req,
	tplq_rsp_if.source  rsp
);
	import tplq_pkg::*;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [HANDLE_W-1:0] mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [HANDLE_W-1:0] mem_rdata;

	// Pointer, count and result control.
	tplq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry store holding all three queues.
	tplq_ram #(
		.DEPTH  (STORE_DEPTH),
		.WIDTH  (HANDLE_W),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[rtl/tplq_chk.sv]
// Port-level checker for the priority queue unit, bound to the top level.
// Depends on tplq_pkg.
module tplq_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tplq_pkg::rsp_t rsp_data
);
	import tplq_pkg::*;

	// A stalled result keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// An empty pop reports level code LVL_HIGH, no handle and no occupancy.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_EMPTY |->
		rsp_data.served_level == LVL_HIGH && rsp_data.out_handle == '0 &&
		rsp_data.occupancy == '0)
		else $error("empty result carries data");

	// Push results, taken or dropped, never carry a handle.
	a_push_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_PUSHED || rsp_data.status == ST_DROPPED) |->
		rsp_data.out_handle == '0)
		else $error("push result carries a handle");

	// A successful push leaves at least one entry in a real level.
	a_push_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_PUSHED |->
		rsp_data.occupancy != '0 && rsp_data.served_level != LVL_INVALID)
		else $error("push result with bad level or occupancy");

	// A pop leaves a queue below its full depth in a real level.
	a_pop_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_POPPED |->
		rsp_data.occupancy < OCC_W'(QUEUE_DEPTH) &&
		rsp_data.served_level != LVL_INVALID)
		else $error("pop result with bad level or occupancy");

endmodule

bind three_level_priority_queue_unit tplq_chk u_tplq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
